// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int CMD_W         = 2;
    localparam int CHAR_W        = 8;
    localparam int ATTR_W        = 8;
    localparam int COLUMN_W      = 7;
    localparam int LINE_W        = 5;
    localparam int CURSOR_CELL_W = 11;
    localparam int CELL_W        = CHAR_W + ATTR_W;

    // character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    // register reset value
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

endpackage

// ===== rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode character buffer with cursor, write, clear, read and scroll.
// ----------------------------------------------------------------------------
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid in_ready cmd character at_position column | sink
//          | line attribute                                     |
//  out     | out_valid out_ready cursor_cell read_character     | source
//          | read_attribute                                     |
//  cfg     | cfg_valid cfg_ready default_attribute              | sink
//
//  the cell index unit (row times columns plus column) is shared: writes and
//  reads use it for the target place and then for the cursor. a write or
//  newline past the last cell scrolls: each cell is copied one row up and
//  the bottom row is blanked. a full result register holds the block in its
//  last state. reset puts the cursor home and the default attribute at 15;
//  the buffer is not cleared. the next input beat is taken while a result
//  waits.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input beats
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]           cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]          character,
    input  logic                                at_position,
    input  logic [tcw_pkg::COLUMN_W-1:0]        column,
    input  logic [tcw_pkg::LINE_W-1:0]          line,
    input  logic [tcw_pkg::ATTR_W-1:0]          attribute,
    // result beats
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tcw_pkg::CURSOR_CELL_W-1:0]   cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]          read_character,
    output logic [tcw_pkg::ATTR_W-1:0]          read_attribute,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]          default_attribute
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int POS_W = $clog2(CELLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ADDR  = 11'b000_0000_0010,
        S_WRITE = 11'b000_0000_0100,
        S_READ  = 11'b000_0000_1000,
        S_RWAIT = 11'b000_0001_0000,
        S_SHIFT = 11'b000_0010_0000,
        S_DRAIN = 11'b000_0100_0000,
        S_ZERO  = 11'b000_1000_0000,
        S_CLEAR = 11'b001_0000_0000,
        S_CURS  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t                         state_reg, state_next;

    logic [tcw_pkg::ATTR_W-1:0]     dflt_attr_reg;
    logic [tcw_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [tcw_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic [tcw_pkg::ATTR_W-1:0]     attr_reg, attr_next;
    logic [ROW_W-1:0]               row_reg, row_next;
    logic [COL_W-1:0]               col_reg, col_next;
    logic [ROW_W-1:0]               cur_row_reg, cur_row_next;
    logic [COL_W-1:0]               cur_col_reg, cur_col_next;
    logic [POS_W-1:0]               cnt_reg, cnt_next;
    logic                           pend_reg, pend_next;
    logic [POS_W-1:0]               wr_addr_reg, wr_addr_next;
    logic [tcw_pkg::CHAR_W-1:0]     rd_char_reg, rd_char_next;
    logic [tcw_pkg::ATTR_W-1:0]     rd_attr_reg, rd_attr_next;

    logic                           out_valid_reg, out_valid_next;
    logic [POS_W-1:0]               out_cell_reg, out_cell_next;
    logic [tcw_pkg::CHAR_W-1:0]     out_char_reg, out_char_next;
    logic [tcw_pkg::ATTR_W-1:0]     out_attr_reg, out_attr_next;

    logic                           in_fire;
    logic [ROW_W-1:0]               line_sat;
    logic [COL_W-1:0]               col_sat;
    logic [ROW_W-1:0]               pu_row;
    logic [COL_W-1:0]               pu_col;
    logic [POS_W-1:0]               place;

    logic                           ram_we;
    logic [POS_W-1:0]               ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
    logic [POS_W-1:0]               ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // default attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_attr_reg <= tcw_pkg::DEFAULT_ATTR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dflt_attr_reg <= default_attribute;
        end
    end

    // saturate the given position to the screen
    always_comb
    begin
        if (32'(column) > COLUMNS - 1)
        begin
            col_sat = COL_W'(COLUMNS - 1);
        end
        else
        begin
            col_sat = COL_W'(column);
        end
        if (32'(line) > ROWS - 1)
        begin
            line_sat = ROW_W'(ROWS - 1);
        end
        else
        begin
            line_sat = ROW_W'(line);
        end
    end

    // shared index unit: the target place in S_ADDR, the cursor otherwise
    assign pu_row = (state_reg == S_ADDR) ? row_reg : cur_row_reg;
    assign pu_col = (state_reg == S_ADDR) ? col_reg : cur_col_reg;

    tcw_place_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W),
        .POS_W   (POS_W)
    ) u_place (
        .clk   (clk),
        .row   (pu_row),
        .col   (pu_col),
        .place (place)
    );

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (POS_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        attr_next      = attr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        wr_addr_next   = wr_addr_reg;
        rd_char_next   = rd_char_reg;
        rd_attr_next   = rd_attr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cell_next  = out_cell_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        ram_we         = 1'b0;
        ram_waddr      = place;
        ram_wdata      = {attr_reg, char_reg};
        ram_raddr      = place;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next     = cmd;
                    char_next    = character;
                    attr_next    = (attribute == '0) ? dflt_attr_reg : attribute;
                    row_next     = at_position ? line_sat : cur_row_reg;
                    col_next     = at_position ? col_sat : cur_col_reg;
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    cnt_next     = '0;
                    case (cmd)
                        tcw_pkg::CMD_WRITE: state_next = S_ADDR;
                        tcw_pkg::CMD_READ:  state_next = S_ADDR;
                        tcw_pkg::CMD_CLEAR: state_next = S_CLEAR;
                        default:            state_next = S_CURS;
                    endcase
                end
            end

            S_ADDR:
            begin
                state_next = (cmd_reg == tcw_pkg::CMD_READ) ? S_READ : S_WRITE;
            end

            // place the character unless it is a newline, then step the cursor
            S_WRITE:
            begin
                ram_we    = (char_reg != tcw_pkg::NEWLINE_CODE);
                ram_waddr = place;
                ram_wdata = {attr_reg, char_reg};
                if ((char_reg == tcw_pkg::NEWLINE_CODE) ||
                    (32'(col_reg) == COLUMNS - 1))
                begin
                    cur_col_next = '0;
                    if (32'(row_reg) == ROWS - 1)
                    begin
                        cur_row_next = ROW_W'(ROWS - 1);
                        cnt_next     = POS_W'(COLUMNS);
                        pend_next    = 1'b0;
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        cur_row_next = row_reg + ROW_W'(1);
                        state_next   = S_CURS;
                    end
                end
                else
                begin
                    cur_row_next = row_reg;
                    cur_col_next = col_reg + COL_W'(1);
                    state_next   = S_CURS;
                end
            end

            S_READ:
            begin
                ram_raddr  = place;
                state_next = S_RWAIT;
            end

            S_RWAIT:
            begin
                rd_char_next = ram_rdata[tcw_pkg::CHAR_W-1:0];
                rd_attr_next = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                state_next   = S_CURS;
            end

            // scroll: copy each cell one row up, one cell per cycle
            S_SHIFT:
            begin
                ram_raddr    = cnt_reg;
                ram_we       = pend_reg;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = ram_rdata;
                pend_next    = 1'b1;
                wr_addr_next = cnt_reg - POS_W'(COLUMNS);
                if (cnt_reg == POS_W'(CELLS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end

            S_DRAIN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_addr_reg;
                ram_wdata  = ram_rdata;
                pend_next  = 1'b0;
                cnt_next   = POS_W'(CELLS - COLUMNS);
                state_next = S_ZERO;
            end

            // blank the bottom row
            S_ZERO:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                if (cnt_reg == POS_W'(CELLS - 1))
                begin
                    state_next = S_CURS;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end

            // spaces everywhere but the bottom row, which is written to zero
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg < POS_W'(CELLS - COLUMNS))
                begin
                    ram_wdata = {dflt_attr_reg, tcw_pkg::SPACE_CODE};
                end
                else
                begin
                    ram_wdata = '0;
                end
                if (cnt_reg == POS_W'(CELLS - 1))
                begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                    state_next   = S_CURS;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end

            S_CURS:
            begin
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = place;
                    out_char_next  = rd_char_reg;
                    out_attr_next  = rd_attr_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        char_reg     <= char_next;
        attr_reg     <= attr_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        cnt_reg      <= cnt_next;
        wr_addr_reg  <= wr_addr_next;
        rd_char_reg  <= rd_char_next;
        rd_attr_reg  <= rd_attr_next;
        out_cell_reg <= out_cell_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
    end

    assign out_valid      = out_valid_reg;
    assign cursor_cell    = tcw_pkg::CURSOR_CELL_W'(out_cell_reg);
    assign read_character = out_char_reg;
    assign read_attribute = out_attr_reg;

endmodule

// ===== rtl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Character cell buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tcw_place_unit.sv =====
// ----------------------------------------------------------------------------
// tcw_place_unit
// Shared cell index unit: row times columns plus column, registered.
// ----------------------------------------------------------------------------
module tcw_place_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int ROW_W   = $clog2(ROWS),
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int POS_W   = $clog2(COLUMNS * ROWS)
) (
    input  logic             clk,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    output logic [POS_W-1:0] place
);

    logic [POS_W-1:0] place_reg;
    logic [POS_W-1:0] place_next;

    // multiply-add against the fixed row pitch
    assign place_next = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);

    always_ff @(posedge clk)
    begin
        place_reg <= place_next;
    end

    assign place = place_reg;

endmodule

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]           cmd,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [tcw_pkg::CURSOR_CELL_W-1:0]   cursor_cell,
    input  logic [tcw_pkg::CHAR_W-1:0]          read_character,
    input  logic [tcw_pkg::ATTR_W-1:0]          read_attribute,
    input  logic                                cfg_ready
);

    logic clear_busy_reg;
    logic clear_busy_next;

    // follow a clear beat until the block takes input again
    always_comb
    begin
        if (in_valid && in_ready)
        begin
            clear_busy_next = (cmd == tcw_pkg::CMD_CLEAR);
        end
        else if (in_ready)
        begin
            clear_busy_next = 1'b0;
        end
        else
        begin
            clear_busy_next = clear_busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
        end
    end

    // the block is not ready again in the cycle after it accepts a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_cell) &&
            $stable(read_character) && $stable(read_attribute))
        else $error("stalled result changed");

    // no result appears unless a beat was in work
    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without input beat");

    // a clear sends the cursor home
    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg && in_ready |-> cursor_cell == '0)
        else $error("clear result with cursor away from home");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_cell    (cursor_cell),
    .read_character (read_character),
    .read_attribute (read_attribute),
    .cfg_ready      (cfg_ready)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer: a shadow screen and
// cursor track every accepted command and each result beat is compared
// against the reply that the shadow screen gives for the same command.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COLUMNS = tcw_pkg::COLUMNS_DEF;
    localparam int ROWS    = tcw_pkg::ROWS_DEF;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int PHASE_CMDS = 290;

    typedef struct {
        tcw_pkg::cmd_t                  op;
        logic [tcw_pkg::CHAR_W-1:0]     ch;
        logic                           at_pos;
        logic [tcw_pkg::COLUMN_W-1:0]   col;
        logic [tcw_pkg::LINE_W-1:0]     row;
        logic [tcw_pkg::ATTR_W-1:0]     attr;
    } console_cmd_t;

    typedef struct {
        logic [tcw_pkg::CURSOR_CELL_W-1:0] cursor_cell;
        logic [tcw_pkg::CHAR_W-1:0]        rd_char;
        logic [tcw_pkg::ATTR_W-1:0]        rd_attr;
    } console_reply_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    console_cmd_t                      tx_cmd = '{tcw_pkg::CMD_NOP, '0, 1'b0, '0, '0, '0};
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [tcw_pkg::CURSOR_CELL_W-1:0] cursor_cell;
    logic [tcw_pkg::CHAR_W-1:0]        read_character;
    logic [tcw_pkg::ATTR_W-1:0]        read_attribute;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [tcw_pkg::ATTR_W-1:0]        cfg_attr = '0;

    // shadow screen state
    logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
    int unsigned                shadow_cursor = 0;
    logic [tcw_pkg::ATTR_W-1:0] shadow_dflt = tcw_pkg::DEFAULT_ATTR_RESET;

    console_cmd_t   console_cmds [$];
    console_reply_t console_replies [$];
    int             errors = 0;
    bit             steady = 1'b0;
    int             tx_wait = 0;
    int             rx_hold = 0;

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (tx_cmd.op),
        .character         (tx_cmd.ch),
        .at_position       (tx_cmd.at_pos),
        .column            (tx_cmd.col),
        .line              (tx_cmd.row),
        .attribute         (tx_cmd.attr),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .cursor_cell       (cursor_cell),
        .read_character    (read_character),
        .read_attribute    (read_attribute),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .default_attribute (cfg_attr)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #150000000;
        $display("text_console_writer_top: mismatch");
        $finish;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // cell addressed by a command, out-of-range position saturates
    function automatic int unsigned target_cell(console_cmd_t c);
        int unsigned col;
        int unsigned row;
        col = c.col;
        row = c.row;
        if (!c.at_pos)
            return shadow_cursor;
        if (col > COLUMNS - 1)
            col = COLUMNS - 1;
        if (row > ROWS - 1)
            row = ROWS - 1;
        return row * COLUMNS + col;
    endfunction

    // move every row up by one, bottom row cleared to zero
    function automatic void scroll_up();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = '0;
    endfunction

    // write one character or newline, then advance the cursor
    function automatic void place_char(int unsigned pos,
                                       logic [tcw_pkg::CHAR_W-1:0] ch,
                                       logic [tcw_pkg::ATTR_W-1:0] attr);
        int unsigned nxt;
        if (attr == '0)
            attr = shadow_dflt;
        if (ch == tcw_pkg::NEWLINE_CODE)
            pos = (pos / COLUMNS) * COLUMNS + COLUMNS - 1;
        else if (pos < CELLS)
            screen[pos] = {attr, ch};
        nxt = pos + 1;
        if (nxt >= CELLS)
        begin
            scroll_up();
            shadow_cursor = nxt - COLUMNS;
        end
        else
            shadow_cursor = nxt;
    endfunction

    // apply one command to the shadow screen and form its reply
    function automatic console_reply_t apply_console_cmd(console_cmd_t c);
        console_reply_t r;
        int unsigned    p;
        r = '{'0, '0, '0};
        case (c.op)
            tcw_pkg::CMD_WRITE:
                place_char(target_cell(c), c.ch, c.attr);
            tcw_pkg::CMD_CLEAR:
            begin
                // last space written runs past the end and scrolls
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {shadow_dflt, tcw_pkg::SPACE_CODE};
                scroll_up();
                shadow_cursor = 0;
            end
            tcw_pkg::CMD_READ:
            begin
                p = target_cell(c);
                r.rd_char = screen[p][tcw_pkg::CHAR_W-1:0];
                r.rd_attr = screen[p][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            default:
                ;
        endcase
        r.cursor_cell = tcw_pkg::CURSOR_CELL_W'(shadow_cursor);
        return r;
    endfunction

    function automatic console_cmd_t make_cmd(tcw_pkg::cmd_t op, int ch, bit at_pos,
                                              int col, int row, int attr);
        console_cmd_t c;
        c.op     = op;
        c.ch     = tcw_pkg::CHAR_W'(ch);
        c.at_pos = at_pos;
        c.col    = tcw_pkg::COLUMN_W'(col);
        c.row    = tcw_pkg::LINE_W'(row);
        c.attr   = tcw_pkg::ATTR_W'(attr);
        return c;
    endfunction

    // random command mix, mostly writes with some newlines, reads, no-ops and clears
    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int unsigned  pick;
        pick     = $urandom_range(0, 99);
        c.op     = tcw_pkg::CMD_WRITE;
        c.ch     = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        c.at_pos = 1'($urandom_range(0, 1));
        c.col    = tcw_pkg::COLUMN_W'($urandom_range(0, 127));
        c.row    = tcw_pkg::LINE_W'($urandom_range(0, 31));
        c.attr   = tcw_pkg::ATTR_W'($urandom_range(0, 255));
        if (pick < 2)
            c.op = tcw_pkg::CMD_CLEAR;
        else if (pick < 6)
            c.op = tcw_pkg::CMD_NOP;
        else if (pick < 24)
            c.op = tcw_pkg::CMD_READ;
        else
        begin
            c.at_pos = ($urandom_range(0, 9) < 3);
            if (pick < 34)
                c.ch = tcw_pkg::NEWLINE_CODE;
            if ($urandom_range(0, 4) == 0)
                c.attr = '0;
        end
        return c;
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                console_replies.push_back(apply_console_cmd(tx_cmd));
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    in_valid <= 1'b0;
                    tx_wait  <= tx_wait - 1;
                end
                else if (console_cmds.size() > 0)
                begin
                    tx_cmd   <= console_cmds.pop_front();
                    in_valid <= 1'b1;
                    tx_wait  <= steady ? 0 : $urandom_range(0, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_side
        int             draw;
        console_reply_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (console_replies.size() == 0)
                report($sformatf("result beat with nothing pending, cursor_cell %0d",
                                 cursor_cell));
            else
            begin
                want = console_replies.pop_front();
                if (cursor_cell !== want.cursor_cell)
                    report($sformatf("cursor_cell got %0d want %0d",
                                     cursor_cell, want.cursor_cell));
                if (read_character !== want.rd_char)
                    report($sformatf("read_character got %0h want %0h",
                                     read_character, want.rd_char));
                if (read_attribute !== want.rd_attr)
                    report($sformatf("read_attribute got %0h want %0h",
                                     read_attribute, want.rd_attr));
            end
            draw = steady ? 0 : $urandom_range(0, 3);
            rx_hold   <= draw;
            out_ready <= (draw == 0);
        end
        else if (rx_hold > 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= (rx_hold == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // block idle: nothing queued, nothing in flight, sampled once edges settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (console_cmds.size() != 0 || in_valid || console_replies.size() != 0);
    endtask

    // stimulus and phase control
    initial
    begin : stimulus
        logic [tcw_pkg::ATTR_W-1:0] attr_plan [5];
        int                         nl;
        nl           = int'(tcw_pkg::NEWLINE_CODE);
        attr_plan[0] = 8'h00;
        attr_plan[1] = 8'hFF;
        attr_plan[2] = tcw_pkg::ATTR_W'($urandom_range(1, 254));
        attr_plan[3] = tcw_pkg::ATTR_W'($urandom_range(1, 254));
        attr_plan[4] = tcw_pkg::DEFAULT_ATTR_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset default attribute, saturation, newline, scroll, clear
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, 'h41, 1'b1, 0, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, 'hFF, 1'b0, 0, 0, 'hFF));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 0, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 1, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, nl, 1'b0, 0, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, 'h55, 1'b0, 0, 0, 'h2A));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 0, 1, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_NOP, 'hFF, 1'b1, 127, 31, 'hFF));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, nl, 1'b1, 5, 3, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, 'h00, 1'b1, 127, 31, 'h80));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 79, 23, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 127, 31, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b0, 0, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, nl, 1'b1, 0, 24, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, 'h7E, 1'b0, 0, 0, 'h01));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_CLEAR, 'hFF, 1'b1, 127, 31, 'hFF));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b0, 0, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 79, 24, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 0, 1'b1, 79, 23, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_WRITE, 'h20, 1'b0, 0, 0, 0));
        console_cmds.push_back(make_cmd(tcw_pkg::CMD_NOP, 0, 1'b0, 0, 0, 0));

        // random phases, each under its own default attribute
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_idle();
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_attr  <= attr_plan[phase];
            do
                @(posedge clk);
            while (!(cfg_valid && cfg_ready));
            cfg_valid   <= 1'b0;
            shadow_dflt = cfg_attr;
            steady      = (phase == 2);
            repeat (PHASE_CMDS) console_cmds.push_back(random_cmd());
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("text_console_writer_top: match");
        else
            $display("text_console_writer_top: mismatch");
        $finish;
    end

endmodule
